// ===== hdl/kwmh_pkg.sv =====
// ----------------------------------------------------------------------------
// kwmh_pkg
// Shared types, constants and codes of the k-way merge heap with accumulation.
// ----------------------------------------------------------------------------
package kwmh_pkg;

    localparam int MAX_SOURCES = 64;
    localparam int RANK_BITS   = 24;

    localparam int WORD_W = 24;
    localparam int VAL_W  = 48;
    localparam int SRC_W  = 6;
    localparam int ACT_W  = 2;
    localparam int STS_W  = 2;
    localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
    localparam int ADDR_W = $clog2(MAX_SOURCES);
    localparam int KEY_W  = 2 * RANK_BITS;
    localparam int CMP_W  = ADDR_W + 1;

    typedef logic [RANK_BITS-1:0] t_rank;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [CMP_W-1:0]     t_cmp;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

    // Status codes
    localparam logic [STS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] in_word1;
        logic [WORD_W-1:0] in_word2;
        logic [VAL_W-1:0]  in_value;
        logic [SRC_W-1:0]  in_source;
    } t_in_item;

    typedef struct packed {
        logic              out_valid;
        logic [WORD_W-1:0] out_word1;
        logic [WORD_W-1:0] out_word2;
        logic [VAL_W-1:0]  out_value;
        logic [SRC_W-1:0]  popped_source;
        logic [CNT_W-1:0]  entry_count;
        logic [STS_W-1:0]  status;
    } t_out_item;

    // One heap slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [SRC_W-1:0] source;
    } t_rec;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INS_LOAD,
        OP_INS_FULL,
        OP_POP_EMPTY,
        OP_FLUSH,
        OP_RD_PARENT,
        OP_UP_MOVE,
        OP_RD_ROOT_LAST,
        OP_POP_TAKE,
        OP_RD_CHILD,
        OP_DN_MOVE,
        OP_PLACE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   clear;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic no_child;
        logic up_move;
        logic dn_move;
    } t_dp_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_POP_TAKE,
        ST_DN_CHK,
        ST_DN_CMP,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/kway_merge_heap_accumulate.sv =====
// ----------------------------------------------------------------------------
// kway_merge_heap_accumulate
// Binary min-heap merging sorted record streams, folding equal keys together.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise start while busy is low; the item is taken at that
//   clock edge and busy rises on the next cycle. One result follows per item:
//   o_result holds it, flagged by o_done for exactly one cycle, and busy drops
//   in the cycle after that. The receiver cannot stall; it must take the
//   result in the cycle o_done is high.
//   Actions: insert a record (sift-up); pop the smallest record (sift-down),
//   folding it into the held record when the keys match, else emitting the
//   held record and holding the popped one; or flush the held record.
//   Each heap compare is a registered read of the parent or of both
//   children, followed by a compare-and-write; the record is written into
//   its slot when the walk stops. Flush and rejected items go straight to
//   the result. The next item is accepted in the cycle right after o_done.
//   Reset: the heap count and the held record clear synchronously; slot
//   memory is not cleared, since only slots below the count are ever used.
// ----------------------------------------------------------------------------
module kway_merge_heap_accumulate (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  kwmh_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output kwmh_pkg::t_out_item o_result
);

    kwmh_pkg::t_dp_cmd  w_cmd;
    kwmh_pkg::t_dp_stat w_stat;

    // Sequencer: decodes the action and steps through the sift
    kwmh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // Datapath: slot memory, moving record, held record, result register
    kwmh_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // Result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done strobe held longer than one cycle");

    // Accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // Count never exceeds the slot count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.entry_count <= kwmh_pkg::CNT_W'(kwmh_pkg::MAX_SOURCES)))
        else $error("entry count out of range");

    // Rejected insert only with a full heap
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == kwmh_pkg::STATUS_FULL)) |->
        (o_result.entry_count == kwmh_pkg::CNT_W'(kwmh_pkg::MAX_SOURCES)))
        else $error("insert rejected while heap not full");

    // Rejected pop emits nothing and leaves the heap empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == kwmh_pkg::STATUS_EMPTY)) |->
        ((o_result.entry_count == '0) && !o_result.out_valid))
        else $error("empty pop produced output or nonzero count");
`endif

endmodule

// ===== hdl/kwmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// kwmh_ctrl
// Sequencer for insert, pop and flush: walks the heap one level per read and compare.
// ----------------------------------------------------------------------------
module kwmh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_action,
    input  kwmh_pkg::t_dp_stat  i_stat,
    output kwmh_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy,
    output logic                o_done
);

    kwmh_pkg::t_state r_state;
    kwmh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwmh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = kwmh_pkg::OP_NONE;
        o_cmd.clear = 1'b0;
        o_busy      = 1'b1;
        o_done      = 1'b0;
        case (r_state)
            kwmh_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.clear = 1'b1;
                    n_state     = kwmh_pkg::ST_DONE;
                    case (i_action)
                        kwmh_pkg::ACT_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.op = kwmh_pkg::OP_INS_FULL;
                            end else begin
                                o_cmd.op = kwmh_pkg::OP_INS_LOAD;
                                n_state  = kwmh_pkg::ST_UP_CHK;
                            end
                        end
                        kwmh_pkg::ACT_POP: begin
                            if (i_stat.empty) begin
                                o_cmd.op = kwmh_pkg::OP_POP_EMPTY;
                            end else begin
                                o_cmd.op = kwmh_pkg::OP_RD_ROOT_LAST;
                                n_state  = kwmh_pkg::ST_POP_TAKE;
                            end
                        end
                        kwmh_pkg::ACT_FLUSH: begin
                            o_cmd.op = kwmh_pkg::OP_FLUSH;
                        end
                        default: begin
                            o_cmd.op = kwmh_pkg::OP_NONE;
                        end
                    endcase
                end
            end
            kwmh_pkg::ST_UP_CHK: begin
                if (i_stat.at_root) begin
                    o_cmd.op = kwmh_pkg::OP_PLACE;
                    n_state  = kwmh_pkg::ST_DONE;
                end else begin
                    o_cmd.op = kwmh_pkg::OP_RD_PARENT;
                    n_state  = kwmh_pkg::ST_UP_CMP;
                end
            end
            kwmh_pkg::ST_UP_CMP: begin
                if (i_stat.up_move) begin
                    o_cmd.op = kwmh_pkg::OP_UP_MOVE;
                    n_state  = kwmh_pkg::ST_UP_CHK;
                end else begin
                    o_cmd.op = kwmh_pkg::OP_PLACE;
                    n_state  = kwmh_pkg::ST_DONE;
                end
            end
            kwmh_pkg::ST_POP_TAKE: begin
                o_cmd.op = kwmh_pkg::OP_POP_TAKE;
                n_state  = kwmh_pkg::ST_DN_CHK;
            end
            kwmh_pkg::ST_DN_CHK: begin
                if (i_stat.no_child) begin
                    o_cmd.op = kwmh_pkg::OP_PLACE;
                    n_state  = kwmh_pkg::ST_DONE;
                end else begin
                    o_cmd.op = kwmh_pkg::OP_RD_CHILD;
                    n_state  = kwmh_pkg::ST_DN_CMP;
                end
            end
            kwmh_pkg::ST_DN_CMP: begin
                if (i_stat.dn_move) begin
                    o_cmd.op = kwmh_pkg::OP_DN_MOVE;
                    n_state  = kwmh_pkg::ST_DN_CHK;
                end else begin
                    o_cmd.op = kwmh_pkg::OP_PLACE;
                    n_state  = kwmh_pkg::ST_DONE;
                end
            end
            kwmh_pkg::ST_DONE: begin
                o_done  = 1'b1;
                n_state = kwmh_pkg::ST_IDLE;
            end
            default: begin
                n_state = kwmh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/kwmh_dp.sv =====
// ----------------------------------------------------------------------------
// kwmh_dp
// Heap memory, moving record, held record and result register.
// ----------------------------------------------------------------------------
module kwmh_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kwmh_pkg::t_in_item  i_item,
    input  kwmh_pkg::t_dp_cmd   i_cmd,
    output kwmh_pkg::t_dp_stat  o_stat,
    output kwmh_pkg::t_out_item o_result
);

    // Heap slots, two read ports with registered data, one write port
    kwmh_pkg::t_rec r_mem [kwmh_pkg::MAX_SOURCES];
    kwmh_pkg::t_rec r_rd_a;
    kwmh_pkg::t_rec r_rd_b;

    logic [kwmh_pkg::CNT_W-1:0]  r_size;
    logic [kwmh_pkg::ADDR_W-1:0] r_hole;
    logic [kwmh_pkg::ADDR_W-1:0] r_par;
    logic [kwmh_pkg::ADDR_W-1:0] r_left;
    kwmh_pkg::t_rec              r_x;
    logic [kwmh_pkg::KEY_W-1:0]  r_held_key;
    logic [kwmh_pkg::VAL_W-1:0]  r_held_val;
    logic                        r_held_present;
    kwmh_pkg::t_out_item         r_res;
    kwmh_pkg::t_out_item         n_res;

    logic [kwmh_pkg::ADDR_W-1:0] w_ra;
    logic [kwmh_pkg::ADDR_W-1:0] w_rb;
    logic                        w_we;
    logic [kwmh_pkg::ADDR_W-1:0] w_wa;
    kwmh_pkg::t_rec              w_wd;
    logic [kwmh_pkg::ADDR_W-1:0] w_parent;
    logic [kwmh_pkg::CMP_W-1:0]  w_left;
    logic [kwmh_pkg::CNT_W-1:0]  w_last;
    logic                        w_right_ok;
    logic                        w_pick_left;
    kwmh_pkg::t_rec              w_pick;
    logic [kwmh_pkg::ADDR_W-1:0] w_pick_addr;
    logic [kwmh_pkg::VAL_W:0]    w_sum;
    kwmh_pkg::t_rec              w_new;

    assign w_parent = (r_hole - 1'b1) >> 1;
    assign w_left   = {r_hole, 1'b1};
    assign w_last   = r_size - 1'b1;

    assign w_right_ok  = (kwmh_pkg::t_cmp'(r_left) + 1'b1) < kwmh_pkg::t_cmp'(r_size);
    assign w_pick_left = !w_right_ok || (r_rd_a.key < r_rd_b.key);
    assign w_pick      = w_pick_left ? r_rd_a : r_rd_b;
    assign w_pick_addr = w_pick_left ? r_left : (r_left + 1'b1);

    assign w_sum = {1'b0, r_held_val} + {1'b0, r_rd_a.value};

    assign w_new.key    = {kwmh_pkg::t_rank'(i_item.in_word1),
                           kwmh_pkg::t_rank'(i_item.in_word2)};
    assign w_new.value  = i_item.in_value;
    assign w_new.source = i_item.in_source;

    assign o_stat.full     = r_size == kwmh_pkg::CNT_W'(kwmh_pkg::MAX_SOURCES);
    assign o_stat.empty    = r_size == '0;
    assign o_stat.at_root  = r_hole == '0;
    assign o_stat.no_child = w_left >= kwmh_pkg::t_cmp'(r_size);
    assign o_stat.up_move  = r_rd_a.key > r_x.key;
    assign o_stat.dn_move  = r_x.key > w_pick.key;

    // Memory port selection
    always_comb begin
        w_ra = w_parent;
        w_rb = w_left[kwmh_pkg::ADDR_W-1:0] + 1'b1;
        w_we = 1'b0;
        w_wa = r_hole;
        w_wd = r_x;
        case (i_cmd.op)
            kwmh_pkg::OP_RD_ROOT_LAST: begin
                w_ra = '0;
                w_rb = w_last[kwmh_pkg::ADDR_W-1:0];
            end
            kwmh_pkg::OP_RD_CHILD: begin
                w_ra = w_left[kwmh_pkg::ADDR_W-1:0];
            end
            kwmh_pkg::OP_UP_MOVE: begin
                w_we = 1'b1;
                w_wd = r_rd_a;
            end
            kwmh_pkg::OP_DN_MOVE: begin
                w_we = 1'b1;
                w_wd = w_pick;
            end
            kwmh_pkg::OP_PLACE: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_a <= r_mem[w_ra];
        r_rd_b <= r_mem[w_rb];
    end

    // Control state: fill count, held flag and held record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size         <= '0;
            r_held_present <= 1'b0;
            r_held_key     <= '0;
            r_held_val     <= '0;
        end else begin
            case (i_cmd.op)
                kwmh_pkg::OP_INS_LOAD: begin
                    r_size <= r_size + 1'b1;
                end
                kwmh_pkg::OP_POP_TAKE: begin
                    r_size <= w_last;
                    if (r_held_present && (r_held_key == r_rd_a.key)) begin
                        r_held_val <= w_sum[kwmh_pkg::VAL_W] ? '1 : w_sum[kwmh_pkg::VAL_W-1:0];
                    end else begin
                        r_held_key     <= r_rd_a.key;
                        r_held_val     <= r_rd_a.value;
                        r_held_present <= 1'b1;
                    end
                end
                kwmh_pkg::OP_FLUSH: begin
                    r_held_present <= 1'b0;
                    r_held_key     <= '0;
                    r_held_val     <= '0;
                end
                default: begin
                    r_size <= r_size;
                end
            endcase
        end
    end

    // Next result payload: clear on accept, then fill in what the item reports
    always_comb begin
        if (i_cmd.clear) begin
            n_res = '0;
        end else begin
            n_res = r_res;
        end
        case (i_cmd.op)
            kwmh_pkg::OP_INS_FULL: begin
                n_res.status = kwmh_pkg::STATUS_FULL;
            end
            kwmh_pkg::OP_POP_EMPTY: begin
                n_res.status = kwmh_pkg::STATUS_EMPTY;
            end
            kwmh_pkg::OP_FLUSH: begin
                if (r_held_present) begin
                    n_res.out_valid = 1'b1;
                    n_res.out_word1 = kwmh_pkg::t_word'(
                        r_held_key[kwmh_pkg::KEY_W-1 -: kwmh_pkg::RANK_BITS]);
                    n_res.out_word2 = kwmh_pkg::t_word'(
                        r_held_key[kwmh_pkg::RANK_BITS-1:0]);
                    n_res.out_value = r_held_val;
                end
            end
            kwmh_pkg::OP_POP_TAKE: begin
                n_res.popped_source = r_rd_a.source;
                if (r_held_present && (r_held_key != r_rd_a.key)) begin
                    n_res.out_valid = 1'b1;
                    n_res.out_word1 = kwmh_pkg::t_word'(
                        r_held_key[kwmh_pkg::KEY_W-1 -: kwmh_pkg::RANK_BITS]);
                    n_res.out_word2 = kwmh_pkg::t_word'(
                        r_held_key[kwmh_pkg::RANK_BITS-1:0]);
                    n_res.out_value = r_held_val;
                end
            end
            default: ;
        endcase
    end

    // Moving record, hole position and result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        case (i_cmd.op)
            kwmh_pkg::OP_INS_LOAD: begin
                r_x    <= w_new;
                r_hole <= r_size[kwmh_pkg::ADDR_W-1:0];
            end
            kwmh_pkg::OP_RD_PARENT: begin
                r_par <= w_parent;
            end
            kwmh_pkg::OP_UP_MOVE: begin
                r_hole <= r_par;
            end
            kwmh_pkg::OP_POP_TAKE: begin
                r_x    <= r_rd_b;
                r_hole <= '0;
            end
            kwmh_pkg::OP_RD_CHILD: begin
                r_left <= w_left[kwmh_pkg::ADDR_W-1:0];
            end
            kwmh_pkg::OP_DN_MOVE: begin
                r_hole <= w_pick_addr;
            end
            default: begin
                r_hole <= r_hole;
            end
        endcase
    end

    always_comb begin
        o_result             = r_res;
        o_result.entry_count = r_size;
    end

endmodule
